// ===== rtl/core/fbfl_pkg.sv =====
// fbfl_pkg: shared types and constants for the fixed block free list pool
// holds transaction payload structs, operation and csr codes, and the
// controller/datapath command and status structs; no dependencies
package fbfl_pkg;

   localparam int OP_W         = 2;
   localparam int INDEX_W      = 6;
   localparam int ADDR_W       = 32;
   localparam int COUNT_W      = 7;
   localparam int BLOCK_SIZE_W = 21;
   localparam int LIMIT_W      = 7;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 32;

   // operation codes
   localparam logic [OP_W-1:0] OP_TAKE    = 2'd0;
   localparam logic [OP_W-1:0] OP_GIVE    = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;
   localparam logic [OP_W-1:0] OP_RESERVE = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_SIZE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_BASE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_LIMIT = 2'd2;

   // register reset values
   localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RST  = 21'd4096;
   localparam logic [ADDR_W-1:0]       POOL_BASE_RST   = 32'd0;
   localparam logic [LIMIT_W-1:0]      BLOCK_LIMIT_RST = 7'd64;

   typedef logic [INDEX_W-1:0] index_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] block_index;
      logic [ADDR_W-1:0]  address;
      logic [COUNT_W-1:0] reserve_count;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [INDEX_W-1:0] result_index;
      logic [ADDR_W-1:0]  block_address;
      logic [COUNT_W-1:0] reserved_done;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;   // capture request, clear working result
      logic take_new;   // create a block and hand it out at once
      logic mem_read;   // read link of the list head
      logic pop;        // head takes the link just read
      logic give;       // push a block back
      logic create;     // create a block onto the list (reserve)
      logic mul_en;     // load the product register
      logic mul_span;   // multiplier operand: created count, else index
      logic div_start;  // load divider
      logic div_step;   // one quotient bit
      logic addr_add;   // base address of the working index
      logic emit;       // move working result to the output register
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            head_null;
      logic            can_create;
      logic            lookup_hit;
      logic            div_last;
      logic            resv_more;
      logic            out_free;
   } dp_sts_type;

endpackage

// ===== rtl/core/fbfl_dpath.sv =====
// fbfl_dpath: datapath of the block pool: csr registers, link memory, list head,
// multiplier, shift-subtract divider and output register
// depends on fbfl_pkg
module fbfl_dpath
   import fbfl_pkg::*;
#(
   parameter int MAX_BLOCKS = 64,
   parameter int ADDR_BITS  = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  ctl_cmd_type            cmd,
   output dp_sts_type             sts
);

   // links and counts hold 0..MAX_BLOCKS, MAX_BLOCKS being the null link
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int PROD_W = CNT_W + BLOCK_SIZE_W;
   localparam int HIT_W  = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;
   localparam int SUM_W  = HIT_W + 1;
   localparam int DIV_W  = BLOCK_SIZE_W + CNT_W - 1;
   localparam int DCMP_W = (DIV_W > ADDR_W) ? DIV_W : ADDR_W;
   localparam int DCNT_W = $clog2(CNT_W) + 1;
   localparam logic [CNT_W-1:0]  NULL_LINK = CNT_W'(MAX_BLOCKS);
   localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
                                           : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

   logic [CNT_W-1:0] link_mem [MAX_BLOCKS];

   req_type                  req_ff, req_in;
   logic [BLOCK_SIZE_W-1:0]  bs_ff, bs_in;
   logic [ADDR_W-1:0]        base_ff, base_in;
   logic [LIMIT_W-1:0]       limit_ff, limit_in;
   logic [CNT_W-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]         created_ff, created_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic                     ok_ff, ok_in;
   logic [ADDR_W-1:0]        baddr_ff, baddr_in;
   logic [COUNT_W-1:0]       done_ff, done_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [ADDR_W-1:0]        rem_ff, rem_in;
   logic [DIV_W-1:0]         div_ff, div_in;
   logic [DCNT_W-1:0]        dcnt_ff, dcnt_in;
   logic [CNT_W-1:0]         rd_link_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   logic [CNT_W-1:0]         mem_wdata;
   logic                     give_ok;
   logic [ADDR_W-1:0]        diff;
   logic                     div_ge;
   logic [SUM_W-1:0]         sum;
   logic [CNT_W-1:0]         mul_a;

   assign give_ok = 32'(req_ff.block_index) < MAX_BLOCKS;
   assign diff    = req_ff.address - base_ff;
   assign div_ge  = DCMP_W'(rem_ff) >= DCMP_W'(div_ff);
   assign sum     = SUM_W'(base_ff) + SUM_W'(prod_ff);
   assign mul_a   = cmd.mul_span ? created_ff : idx_ff;

   assign sts.op         = req_ff.op;
   assign sts.head_null  = head_ff >= NULL_LINK;
   assign sts.can_create = (CMP_W'(created_ff) < CMP_W'(limit_ff)) && (created_ff < NULL_LINK);
   assign sts.lookup_hit = (bs_ff != '0) && (req_ff.address >= base_ff)
                           && (HIT_W'(diff) < HIT_W'(prod_ff));
   assign sts.div_last   = dcnt_ff == '0;
   assign sts.resv_more  = done_ff < req_ff.reserve_count;
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   // link memory write port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = created_ff[IDX_W-1:0];
      mem_wdata = head_ff;
      if (cmd.take_new) begin
         mem_we    = 1'b1;
         mem_wdata = NULL_LINK;
      end else if (cmd.create) begin
         mem_we    = 1'b1;
      end else if (cmd.give && give_ok) begin
         mem_we    = 1'b1;
         mem_waddr = IDX_W'(req_ff.block_index);
      end
   end

   always_comb begin
      req_in       = req_ff;
      bs_in        = bs_ff;
      base_in      = base_ff;
      limit_in     = limit_ff;
      head_in      = head_ff;
      created_in   = created_ff;
      idx_in       = idx_ff;
      ok_in        = ok_ff;
      baddr_in     = baddr_ff;
      done_in      = done_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_BLOCK_SIZE:  bs_in    = csr_wdata[BLOCK_SIZE_W-1:0];
            CSR_POOL_BASE:   base_in  = csr_wdata[ADDR_W-1:0];
            CSR_BLOCK_LIMIT: limit_in = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load_req) begin
         req_in   = req_data;
         ok_in    = 1'b0;
         idx_in   = '0;
         baddr_in = '0;
         done_in  = '0;
      end
      // created block is popped straight away, so the head stays null
      if (cmd.take_new) begin
         idx_in     = created_ff;
         ok_in      = 1'b1;
         created_in = created_ff + CNT_W'(1);
      end
      if (cmd.mem_read) begin
         idx_in = head_ff;
         ok_in  = 1'b1;
      end
      if (cmd.pop) begin
         head_in = rd_link_ff;
      end
      if (cmd.give && give_ok) begin
         head_in = CNT_W'(req_ff.block_index);
      end
      if (cmd.create) begin
         head_in    = created_ff;
         created_in = created_ff + CNT_W'(1);
         done_in    = done_ff + COUNT_W'(1);
      end
      if (cmd.mul_en) begin
         prod_in = PROD_W'(mul_a) * PROD_W'(bs_ff);
      end
      // quotient is below the created count, so CNT_W bits suffice
      if (cmd.div_start) begin
         ok_in   = 1'b1;
         idx_in  = '0;
         rem_in  = diff;
         div_in  = DIV_W'(bs_ff) << (CNT_W - 1);
         dcnt_in = DCNT_W'(CNT_W - 1);
      end
      if (cmd.div_step) begin
         if (div_ge) begin
            rem_in = rem_ff - ADDR_W'(div_ff);
         end
         idx_in  = (idx_ff << 1) | CNT_W'(div_ge);
         div_in  = div_ff >> 1;
         dcnt_in = dcnt_ff - DCNT_W'(1);
      end
      if (cmd.addr_add) begin
         baddr_in = sum[ADDR_W-1:0] & ADDR_MASK;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in         = 1'b1;
         rsp_in.ok            = ok_ff;
         rsp_in.result_index  = index_type'(idx_ff);
         rsp_in.block_address = baddr_ff;
         rsp_in.reserved_done = done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff        <= BLOCK_SIZE_RST;
         base_ff      <= POOL_BASE_RST;
         limit_ff     <= BLOCK_LIMIT_RST;
         head_ff      <= NULL_LINK;
         created_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bs_ff        <= bs_in;
         base_ff      <= base_in;
         limit_ff     <= limit_in;
         head_ff      <= head_in;
         created_ff   <= created_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      idx_ff   <= idx_in;
      ok_ff    <= ok_in;
      baddr_ff <= baddr_in;
      done_ff  <= done_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      dcnt_ff  <= dcnt_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.mem_read) begin
         rd_link_ff <= link_mem[head_ff[IDX_W-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/fbfl_ctrl.sv =====
// fbfl_ctrl: sequencing state machine of the block pool
// drives datapath commands from its status; depends on fbfl_pkg
module fbfl_ctrl
   import fbfl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dp_sts_type  sts,
   output ctl_cmd_type cmd
);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_EXEC    = 9'b000000010,
      S_TAKE_RD = 9'b000000100,
      S_CHECK   = 9'b000001000,
      S_DIV     = 9'b000010000,
      S_RESV    = 9'b000100000,
      S_MUL     = 9'b001000000,
      S_ADD     = 9'b010000000,
      S_DONE    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            case (sts.op)
               OP_TAKE: begin
                  if (!sts.head_null) begin
                     cmd.mem_read = 1'b1;
                     state_in     = S_TAKE_RD;
                  end else if (sts.can_create) begin
                     cmd.take_new = 1'b1;
                     state_in     = S_MUL;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               OP_GIVE: begin
                  cmd.give = 1'b1;
                  state_in = S_DONE;
               end
               OP_LOOKUP: begin
                  // span of created blocks for the range check
                  cmd.mul_en   = 1'b1;
                  cmd.mul_span = 1'b1;
                  state_in     = S_CHECK;
               end
               OP_RESERVE: state_in = S_RESV;
               default:    state_in = S_DONE;
            endcase
         end
         S_TAKE_RD: begin
            cmd.pop  = 1'b1;
            state_in = S_MUL;
         end
         S_CHECK: begin
            if (sts.lookup_hit) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_MUL;
            end
         end
         S_RESV: begin
            if (sts.resv_more && sts.can_create) begin
               cmd.create = 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_ADD;
         end
         S_ADD: begin
            cmd.addr_add = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/fixed_block_free_list_pool.sv =====
// fixed_block_free_list_pool: top level of the fixed-size block pool
// joins the controller fbfl_ctrl and the datapath fbfl_dpath; depends on fbfl_pkg
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_data  (req_type)
//   rsp      out        rsp_valid / rsp_stall   rsp_data  (rsp_type)
//   csr      in         csr_wr_en               csr_index, csr_wdata
//
// one transaction at a time; a take that gets a block, and a lookup hit, end
// with a multiply and an add; a hit divides first (one quotient bit per cycle);
// reserve makes its blocks with one link write per cycle.
// the output register lets the next transaction be taken while a result waits.
// reset is synchronous and needs no clearing pass; a stalled result holds.
module fixed_block_free_list_pool
   import fbfl_pkg::*;
#(
   parameter int MAX_BLOCKS = 64,
   parameter int ADDR_BITS  = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   fbfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fbfl_dpath #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// ===== tb/sv/fbfl_pool_checker.sv =====
// fbfl_pool_checker: watches the req, rsp and csr ports of the block pool,
// keeps its own copy of the free list and registers, and compares each result
// with the outcome worked out for it; depends on fbfl_pkg
module fbfl_pool_checker
   import fbfl_pkg::*;
#(
   parameter int MAX_BLOCKS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   localparam logic [COUNT_W-1:0] LINK_NULL = COUNT_W'(MAX_BLOCKS);

   logic [COUNT_W-1:0]      link_mem [MAX_BLOCKS];
   logic [COUNT_W-1:0]      head;
   logic [COUNT_W-1:0]      created;
   logic [BLOCK_SIZE_W-1:0] blk_size;
   logic [ADDR_W-1:0]       base;
   logic [LIMIT_W-1:0]      limit;
   rsp_type                 outcome_q [$];
   int                      shown;

   function automatic logic [ADDR_W-1:0] block_base(logic [63:0] idx);
      logic [63:0] a;
      a = 64'(base) + idx * 64'(blk_size);
      return a[ADDR_W-1:0];
   endfunction

   // new block goes on top of the free list
   function automatic bit grow_pool();
      logic [LIMIT_W-1:0] cap;
      cap = (limit > LIMIT_W'(MAX_BLOCKS)) ? LIMIT_W'(MAX_BLOCKS) : limit;
      if (created >= cap || created >= LINK_NULL) return 1'b0;
      link_mem[created] = head;
      head = created;
      created = created + 1'b1;
      return 1'b1;
   endfunction

   function automatic rsp_type pool_outcome(req_type r);
      rsp_type            o;
      logic [63:0]        span;
      logic [63:0]        off;
      logic [63:0]        idx;
      logic [COUNT_W-1:0] made;
      bit                 have;
      o = '0;
      case (r.op)
         OP_TAKE: begin
            have = 1'b1;
            if (head >= LINK_NULL) have = grow_pool();
            if (have && head < LINK_NULL) begin
               o.ok = 1'b1;
               o.result_index = head[INDEX_W-1:0];
               o.block_address = block_base(64'(head));
               head = link_mem[head];
            end
         end
         OP_GIVE: begin
            // an index beyond the pool is dropped
            if (32'(r.block_index) < MAX_BLOCKS) begin
               link_mem[r.block_index] = head;
               head = {1'b0, r.block_index};
            end
         end
         OP_LOOKUP: begin
            span = 64'(created) * 64'(blk_size);
            off = 64'(r.address) - 64'(base);
            if (blk_size != '0 && r.address >= base && off < span) begin
               idx = off / 64'(blk_size);
               o.ok = 1'b1;
               o.result_index = idx[INDEX_W-1:0];
               o.block_address = block_base(idx);
            end
         end
         default: begin
            made = '0;
            while (made < r.reserve_count && grow_pool()) made = made + 1'b1;
            o.reserved_done = made;
         end
      endcase
      return o;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      bit      bad;
      if (reset) begin
         for (int i = 0; i < MAX_BLOCKS; i++) link_mem[i] = LINK_NULL;
         head = LINK_NULL;
         created = '0;
         blk_size = BLOCK_SIZE_RST;
         base = POOL_BASE_RST;
         limit = BLOCK_LIMIT_RST;
         outcome_q.delete();
      end else begin
         // results first: a result never belongs to a transaction taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               want = '0;
               bad = 1'b1;
               if (shown < 10)
                  $display("unexpected result: ok %0b index %0d address %h reserved %0d",
                     rsp_data.ok, rsp_data.result_index, rsp_data.block_address,
                     rsp_data.reserved_done);
            end else begin
               want = outcome_q.pop_front();
               bad = (rsp_data.ok !== want.ok)
                  || (rsp_data.result_index !== want.result_index)
                  || (rsp_data.block_address !== want.block_address)
                  || (rsp_data.reserved_done !== want.reserved_done);
               if (bad && shown < 10)
                  $display({"mismatch (expected/actual): ok %0b/%0b index %0d/%0d",
                            " address %h/%h reserved %0d/%0d"},
                     want.ok, rsp_data.ok, want.result_index, rsp_data.result_index,
                     want.block_address, rsp_data.block_address,
                     want.reserved_done, rsp_data.reserved_done);
            end
            if (bad) begin
               fail_count++;
               shown++;
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BLOCK_SIZE:  blk_size = csr_wdata[BLOCK_SIZE_W-1:0];
               CSR_POOL_BASE:   base = csr_wdata[ADDR_W-1:0];
               CSR_BLOCK_LIMIT: limit = csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) outcome_q.push_back(pool_outcome(req_data));
      end
      pending <= outcome_q.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// tb: stimulus and verdict for fixed_block_free_list_pool
// drives directed and random transactions under several register settings;
// the checking is done by fbfl_pool_checker; depends on fbfl_pkg
module tb;
   import fbfl_pkg::*;

   localparam int MAX_BLOCKS = 64;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   int                      fail_count;
   int                      pending;
   logic                    hold_request = 1'b0;
   int                      burst_left = 4;
   logic [BLOCK_SIZE_W-1:0] cur_size = BLOCK_SIZE_RST;
   logic [ADDR_W-1:0]       cur_base = POOL_BASE_RST;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   fixed_block_free_list_pool #(.MAX_BLOCKS(MAX_BLOCKS)) i_dut (.*);

   fbfl_pool_checker #(.MAX_BLOCKS(MAX_BLOCKS)) i_checker (.*);

   // offer one transaction, then maybe close the burst with a gap
   task automatic send_item(input req_type r);
      int gap;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // upper data bits carry noise on the narrow registers
   task automatic set_config(input logic [BLOCK_SIZE_W-1:0] bs, input logic [ADDR_W-1:0] pb,
                             input logic [LIMIT_W-1:0] lim);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_BLOCK_SIZE;
      csr_wdata <= {11'($urandom), bs};
      @(posedge clock);
      csr_index <= CSR_POOL_BASE;
      csr_wdata <= pb;
      @(posedge clock);
      csr_index <= CSR_BLOCK_LIMIT;
      csr_wdata <= {25'($urandom), lim};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_size = bs;
      cur_base = pb;
   endtask

   // fields the operation does not use are filled with noise
   function automatic req_type op_req(input logic [OP_W-1:0] op, input logic [31:0] val);
      req_type r;
      r.op = op;
      r.block_index = INDEX_W'($urandom);
      r.address = $urandom;
      r.reserve_count = COUNT_W'($urandom);
      case (op)
         OP_GIVE:    r.block_index = INDEX_W'(val);
         OP_LOOKUP:  r.address = val;
         OP_RESERVE: r.reserve_count = COUNT_W'(val);
         default: ;
      endcase
      return r;
   endfunction

   function automatic req_type random_req();
      int unsigned sel;
      logic [63:0] a;
      sel = $urandom_range(0, 99);
      if (sel < 35) return op_req(OP_TAKE, 0);
      if (sel < 65)
         return op_req(OP_GIVE, ($urandom_range(0, 4) != 0) ? $urandom_range(0, 15)
                                                           : $urandom_range(0, 63));
      if (sel < 88) begin
         // mostly addresses inside some block of the pool
         if ($urandom_range(0, 3) != 0) begin
            a = 64'(cur_base) + 64'($urandom_range(0, MAX_BLOCKS - 1)) * 64'(cur_size)
               + ((cur_size == '0) ? 64'd0 : 64'($urandom % 32'(cur_size)));
            return op_req(OP_LOOKUP, a[31:0]);
         end
         return op_req(OP_LOOKUP, $urandom);
      end
      sel = $urandom_range(0, 9);
      if (sel < 7) return op_req(OP_RESERVE, $urandom_range(0, 4));
      if (sel < 9) return op_req(OP_RESERVE, $urandom_range(0, 127));
      return op_req(OP_RESERVE, ($urandom_range(0, 1) != 0) ? 64 : 127);
   endfunction

   // receiver: stall segments of varying style, one long hold-off on request
   initial begin : receiver
      int mode;
      int seg;
      int k;
      bit hold_taken;
      hold_taken = 1'b0;
      forever begin
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            for (k = 0; k < 300; k++) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
         end
         mode = $urandom_range(0, 3);
         seg = $urandom_range(10, 150);
         for (k = 0; k < seg && !(hold_request && !hold_taken); k++) begin
            @(posedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 9) < 3);
               2: rsp_stall <= ($urandom_range(0, 9) < 7);
               default: rsp_stall <= (k % 4 == 3);
            endcase
         end
      end
   end

   initial begin : stimulus
      logic [BLOCK_SIZE_W-1:0] bs;
      logic [ADDR_W-1:0]       pb;
      logic [LIMIT_W-1:0]      lim;
      int                      phase;
      int                      n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: creation on empty take, lookups, give onto an empty list
      send_item(op_req(OP_TAKE, 0));
      send_item(op_req(OP_TAKE, 0));
      send_item(op_req(OP_LOOKUP, 32'd0));
      send_item(op_req(OP_LOOKUP, 32'd8191));
      send_item(op_req(OP_LOOKUP, 32'd8192));
      send_item(op_req(OP_GIVE, 0));
      send_item(op_req(OP_GIVE, 1));
      send_item(op_req(OP_TAKE, 0));
      send_item(op_req(OP_TAKE, 0));
      send_item(op_req(OP_GIVE, 63));
      send_item(op_req(OP_TAKE, 0));
      send_item(op_req(OP_RESERVE, 0));
      send_item(op_req(OP_RESERVE, 2));

      // limit reached: the last take fails, reserve makes nothing
      set_config(BLOCK_SIZE_RST, POOL_BASE_RST, 7'd5);
      repeat (4) send_item(op_req(OP_TAKE, 0));
      send_item(op_req(OP_RESERVE, 10));

      // zero block size never hits, limit below the created count
      set_config('0, $urandom, '0);
      send_item(op_req(OP_LOOKUP, $urandom));
      send_item(op_req(OP_TAKE, 0));

      // block size of 2**20 at the top of the address space: addresses wrap
      set_config(21'd1048576, 32'hffff_ffff, 7'd20);
      send_item(op_req(OP_RESERVE, 127));
      send_item(op_req(OP_TAKE, 0));
      send_item(op_req(OP_LOOKUP, 32'hffff_ffff));
      send_item(op_req(OP_LOOKUP, 32'd0));
      send_item(op_req(OP_GIVE, 5));
      send_item(op_req(OP_GIVE, 5));
      send_item(op_req(OP_TAKE, 0));

      for (phase = 0; phase < 6; phase++) begin
         case ($urandom_range(0, 6))
            0: bs = 21'd1;
            1: bs = 21'd1048576;
            2: bs = '0;
            3: bs = BLOCK_SIZE_RST;
            4, 5: bs = BLOCK_SIZE_W'($urandom_range(1, 64));
            default: bs = BLOCK_SIZE_W'($urandom_range(1, 1048576));
         endcase
         case ($urandom_range(0, 3))
            0: pb = '0;
            1: pb = 32'hffff_ffff;
            2: pb = $urandom;
            default: pb = $urandom_range(0, 65535);
         endcase
         // early phases keep the pool growing slowly
         if (phase < 2) lim = LIMIT_W'($urandom_range(20, 50));
         else begin
            case ($urandom_range(0, 3))
               0: lim = '0;
               1: lim = 7'd64;
               2: lim = 7'd127;
               default: lim = LIMIT_W'($urandom_range(0, 64));
            endcase
         end
         set_config(bs, pb, lim);
         for (n = 0; n < 85; n++) begin
            if (phase == 2 && n == 20) hold_request <= 1'b1;
            send_item(random_req());
         end
      end

      wait_idle();
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("FAIL");
      $finish;
   end

endmodule
